[sv/primitive_index_fetch_assert.svh]
// Assertion macros for the index fetch block.
`ifndef PRIMITIVE_INDEX_FETCH_ASSERT_SVH
`define PRIMITIVE_INDEX_FETCH_ASSERT_SVH

`ifndef SYNTH
// cond must hold at every clock edge out of reset
`define PIF_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("pif check failed");
// ante at one edge implies cons at the same edge
`define PIF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pif check failed");
`else
`define PIF_ASSERT(lbl, clk, rstn, cond)
`define PIF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/pif_pkg.sv]
package pif_pkg;

  // index store geometry (word count is a power of two)
  localparam int STORE_WORDS = 4096;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int ENT_W       = ADDR_W + 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_INDEXED  = 3'd0;
  localparam logic [2:0] REG_WIDTH    = 3'd1;
  localparam logic [2:0] REG_TOPOLOGY = 3'd2;
  localparam logic [2:0] REG_START    = 3'd3;
  localparam logic [2:0] REG_BASE     = 3'd4;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // topology codes
  localparam logic [1:0] TOPO_LINE_LIST  = 2'd0;
  localparam logic [1:0] TOPO_LINE_STRIP = 2'd1;
  localparam logic [1:0] TOPO_TRI_LIST   = 2'd2;
  localparam logic [1:0] TOPO_TRI_STRIP  = 2'd3;

  typedef struct packed {
    logic        indexed;
    logic        wide;
    logic [1:0]  topology;
    logic [12:0] first_entry;
    logic [31:0] vertex_offset;
  } pif_cfg_t;

  // one queued transaction: a store write or a classified primitive
  typedef struct packed {
    logic                   op;
    logic [ADDR_W-1:0]      waddr;
    logic [31:0]            wdata;
    logic                   triangle;
    logic [2:0][31:0]       id;
    logic [2:0][ADDR_W-1:0] word;
    logic [2:0]             half;
    logic                   first;
    logic                   fin;
  } pif_item_t;

  typedef struct packed {
    logic              full;
    logic              valid;
    logic [QCNT_W-1:0] count;
  } pif_qstat_t;

endpackage

[sv/primitive_index_fetch.sv]
// Primitive index fetcher. Store-write transactions load one 32-bit word into a
// 4096-word index store; fetch transactions name a primitive, which turns into
// two (line) or three (triangle) result transactions carrying each vertex index
// plus the vertex offset and the batch's running bounds after the whole primitive.
// The front classifies and forms vertex ids and store addresses, a two-entry
// queue decouples it from the back, which owns the single-port store. A store
// write is done as it is popped from the queue; a fetch is popped, then reads
// the store for its corners in turn, one store read per cycle, and its results
// wait until every corner's bound is known before they go to the sink.
// The store has no reset; reading a word never written gives an undefined index.
// Configuration may be written only while no transaction is in flight.
`include "primitive_index_fetch_assert.svh"

module primitive_index_fetch
  import pif_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [79:0]       in_tdata,   // word_address[11:0], word_data[43:12], prim_id[75:44]
  input  logic [1:0]        in_tuser,   // operation[0], first_prim[1]
  input  logic              in_tlast,   // final_prim
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,  // vertex_index[31:0], low_bound[63:32], high_bound[95:64]
  output logic [2:0]        out_tuser,  // corner[1:0], batch_done[2]
  output logic              out_tlast,  // last_corner
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  pif_cfg_t   cfg_r;
  pif_qstat_t q_stat;
  pif_item_t  push_item, pop_item;
  logic       q_push, q_pop;
  logic       cfg_wr;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_INDEXED:  cfg_r.indexed       <= cfg_pwdata[0];
        REG_WIDTH:    cfg_r.wide          <= cfg_pwdata[0];
        REG_TOPOLOGY: cfg_r.topology      <= cfg_pwdata[1:0];
        REG_START:    cfg_r.first_entry   <= cfg_pwdata[12:0];
        REG_BASE:     cfg_r.vertex_offset <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_INDEXED:  cfg_prdata = {31'd0, cfg_r.indexed};
      REG_WIDTH:    cfg_prdata = {31'd0, cfg_r.wide};
      REG_TOPOLOGY: cfg_prdata = {30'd0, cfg_r.topology};
      REG_START:    cfg_prdata = {19'd0, cfg_r.first_entry};
      REG_BASE:     cfg_prdata = cfg_r.vertex_offset;
      default:      cfg_prdata = '0;
    endcase
  end

  pif_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  pif_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  pif_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checks
  `PIF_ASSERT_IMP(a_done_on_last, clk, rst_n, out_tvalid && out_tuser[2], out_tlast)
  `PIF_ASSERT_IMP(a_corner2_last, clk, rst_n, out_tvalid && out_tuser[1:0] == 2'd2, out_tlast)
  `PIF_ASSERT_IMP(a_no_push_full, clk, rst_n, q_stat.full, !q_push)
  `PIF_ASSERT(a_count_range, clk, rst_n, q_stat.count <= QCNT_W'(QUEUE_DEPTH))

endmodule

[sv/pif_front.sv]
module pif_front
  import pif_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pif_cfg_t    cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // word_address[11:0], word_data[43:12], prim_id[75:44]
  input  logic [1:0]  in_tuser,   // operation[0], first_prim[1]
  input  logic        in_tlast,   // final_prim
  input  pif_qstat_t  q_stat,
  output logic        q_push,
  output pif_item_t   q_item
);

  logic       valid_r, valid_nxt;
  pif_item_t  item_r, item_nxt;

  logic [31:0]       prim;
  logic [31:0]       p2, p3;
  logic [2:0][31:0]  ids;
  logic              tri_c;
  logic [ENT_W-1:0]  ent [3];

  assign prim = in_tdata[75:44];
  assign p2   = {prim[30:0], 1'b0};
  assign p3   = prim + p2;

  // vertex ids from topology
  always_comb begin
    ids   = '0;
    tri_c = 1'b0;
    case (cfg.topology)
      TOPO_LINE_LIST: begin
        ids[0] = p2;
        ids[1] = p2 + 32'd1;
      end
      TOPO_LINE_STRIP: begin
        ids[0] = prim;
        ids[1] = prim + 32'd1;
      end
      TOPO_TRI_LIST: begin
        tri_c  = 1'b1;
        ids[0] = p3;
        ids[1] = p3 + 32'd1;
        ids[2] = p3 + 32'd2;
      end
      default: begin
        // odd strip primitive swaps first and third corners
        tri_c  = 1'b1;
        ids[1] = prim + 32'd1;
        if (prim[0]) begin
          ids[0] = prim + 32'd2;
          ids[2] = prim;
        end else begin
          ids[0] = prim;
          ids[2] = prim + 32'd2;
        end
      end
    endcase
  end

  // store entry and word address of each corner
  always_comb begin
    item_nxt          = item_r;
    item_nxt.op       = in_tuser[0];
    item_nxt.waddr    = ADDR_W'(in_tdata[11:0]);
    item_nxt.wdata    = in_tdata[43:12];
    item_nxt.triangle = tri_c;
    item_nxt.id       = ids;
    item_nxt.first    = in_tuser[1];
    item_nxt.fin      = in_tlast;
    for (int k = 0; k < 3; k++) begin
      ent[k] = ENT_W'(cfg.first_entry) + ENT_W'(ids[k]);
      item_nxt.word[k] = cfg.wide ? ent[k][ADDR_W-1:0] : ent[k][ENT_W-1:1];
      item_nxt.half[k] = ent[k][0];
    end
  end

  assign q_push    = valid_r && !q_stat.full;
  assign in_tready = !valid_r || !q_stat.full;
  assign q_item    = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (q_push)
      valid_nxt = 1'b0;
    if (in_tvalid && in_tready)
      valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

[sv/pif_fifo.sv]
module pif_fifo
  import pif_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pif_item_t  push_item,
  input  logic       pop,
  output pif_item_t  pop_item,
  output pif_qstat_t stat
);

  pif_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.valid = (count_r != '0);
  assign stat.count = count_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign pop_item   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)
      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push)
      count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[sv/pif_back.sv]
module pif_back
  import pif_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pif_cfg_t    cfg,
  input  pif_qstat_t  q_stat,
  input  pif_item_t   q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // vertex_index[31:0], low_bound[63:32], high_bound[95:64]
  output logic [2:0]  out_tuser,  // corner[1:0], batch_done[2]
  output logic        out_tlast   // last_corner
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  pif_item_t   cur_r;
  logic [1:0]  rd_idx_r, rd_idx_nxt;
  logic [1:0]  acc_idx_r, acc_idx_nxt;
  logic [1:0]  out_idx_r, out_idx_nxt;
  logic        pend_r, pend_nxt;
  logic        half_r;
  logic [31:0] min_r, min_nxt;
  logic [31:0] max_r, max_nxt;
  logic [31:0] raw_r [3];
  logic [31:0] rdata_r;
  logic [31:0] store_r [STORE_WORDS];

  logic [1:0]        last_idx;
  logic              issue;
  logic              take_fetch;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [ADDR_W-1:0] rd_word;
  logic              rd_half;
  logic [31:0]       acc_id;
  logic [31:0]       raw_v;
  logic [31:0]       out_raw;
  logic              last_c;

  assign last_idx = cur_r.triangle ? 2'd2 : 2'd1;
  assign issue    = (state_r == ST_FETCH) && (rd_idx_r <= last_idx);

  // corner selects
  always_comb begin
    case (rd_idx_r)
      2'd0:    begin rd_word = cur_r.word[0]; rd_half = cur_r.half[0]; end
      2'd1:    begin rd_word = cur_r.word[1]; rd_half = cur_r.half[1]; end
      default: begin rd_word = cur_r.word[2]; rd_half = cur_r.half[2]; end
    endcase
    case (acc_idx_r)
      2'd0:    acc_id = cur_r.id[0];
      2'd1:    acc_id = cur_r.id[1];
      default: acc_id = cur_r.id[2];
    endcase
    case (out_idx_r)
      2'd0:    out_raw = raw_r[0];
      2'd1:    out_raw = raw_r[1];
      default: out_raw = raw_r[2];
    endcase
  end

  // single-port index store, registered read
  assign q_pop      = (state_r == ST_IDLE) && q_stat.valid;
  assign mem_we     = q_pop && (q_item.op == OP_WRITE);
  assign take_fetch = q_pop && (q_item.op == OP_FETCH);
  assign mem_addr   = (state_r == ST_IDLE) ? q_item.waddr : rd_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_addr] <= q_item.wdata;
    end
    rdata_r <= store_r[mem_addr];
  end

  // raw index of the corner whose read returns this cycle
  always_comb begin
    if (!cfg.indexed)
      raw_v = acc_id;
    else if (cfg.wide)
      raw_v = rdata_r;
    else
      raw_v = {16'd0, half_r ? rdata_r[31:16] : rdata_r[15:0]};
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    rd_idx_nxt  = rd_idx_r;
    acc_idx_nxt = acc_idx_r;
    out_idx_nxt = out_idx_r;
    pend_nxt    = 1'b0;
    min_nxt     = min_r;
    max_nxt     = max_r;
    case (state_r)
      ST_IDLE: begin
        if (take_fetch) begin
          state_nxt   = ST_FETCH;
          rd_idx_nxt  = 2'd0;
          acc_idx_nxt = 2'd0;
          if (q_item.first) begin
            min_nxt = '1;
            max_nxt = '0;
          end
        end
      end
      ST_FETCH: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 2'd1;
          pend_nxt   = 1'b1;
        end
        if (pend_r) begin
          if (raw_v < min_r)
            min_nxt = raw_v;
          if (raw_v > max_r)
            max_nxt = raw_v;
          acc_idx_nxt = acc_idx_r + 2'd1;
          if (acc_idx_r == last_idx) begin
            state_nxt   = ST_EMIT;
            out_idx_nxt = 2'd0;
          end
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          out_idx_nxt = out_idx_r + 2'd1;
          if (last_c)
            state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_idx_r  <= '0;
      acc_idx_r <= '0;
      out_idx_r <= '0;
      pend_r    <= 1'b0;
      min_r     <= '1;
      max_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      acc_idx_r <= acc_idx_nxt;
      out_idx_r <= out_idx_nxt;
      pend_r    <= pend_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_fetch) begin
      cur_r <= q_item;
    end
    if (issue) begin
      half_r <= rd_half;
    end
    if (state_r == ST_FETCH && pend_r) begin
      if (acc_idx_r == 2'd0) raw_r[0] <= raw_v;
      if (acc_idx_r == 2'd1) raw_r[1] <= raw_v;
      if (acc_idx_r == 2'd2) raw_r[2] <= raw_v;
    end
  end

  // result channel
  assign last_c     = (out_idx_r == last_idx);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {max_r + cfg.vertex_offset, min_r + cfg.vertex_offset,
                       out_raw + cfg.vertex_offset};
  assign out_tuser  = {last_c && cur_r.fin, out_idx_r};
  assign out_tlast  = last_c;

endmodule
